/* rtl/sis_pkg.sv */
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and codes of the sorted integer set: operations, status codes,
// channel payloads and the links between neighboring cells.
// ----------------------------------------------------------------------------
package sis_pkg;

	localparam int DEF_CAPACITY = 64;

	typedef logic signed [31:0] value_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		op_t        operation;
		value_t     value;
		logic [5:0] position;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [6:0] count;
		value_t     element;
		status_t    status;
	} rsp_t;

	// query broadcast to every cell
	typedef struct packed {
		op_t        operation;
		value_t     value;
		logic [5:0] position;
		logic       shift;
	} query_t;

	// handed from a cell to the next higher cell
	typedef struct packed {
		logic   lt;
		value_t data;
	} link_t;

	// answer rippling toward cell zero
	typedef struct packed {
		logic   hit;
		value_t data;
	} ans_t;

endpackage

/* rtl/sis_chan_if.sv */
// ----------------------------------------------------------------------------
// sis_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface sis_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sis_cell.sv */
// ----------------------------------------------------------------------------
// sis_cell
// One slot of the sorted chain: holds an element, compares it with the query,
// shifts up on insert and passes search answers down toward cell zero.
// ----------------------------------------------------------------------------
module sis_cell
	import sis_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int CW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  query_t        query,
	input  logic [CW-1:0] count,
	input  link_t         prev,
	output link_t         link_out,
	input  ans_t          ans_in,
	output ans_t          ans_out
);

	localparam int PW = (CW > 6) ? CW : 6;

	value_t data_q;
	ans_t   ans_q;
	logic   occ;
	logic   lt;
	logic   eq;
	logic   pos_hit;
	logic   hit;

	always_comb begin
		occ     = CW'(INDEX) < count;
		lt      = occ && (data_q < query.value);
		eq      = occ && (data_q == query.value);
		pos_hit = occ && (PW'(INDEX) == PW'(query.position));
		hit     = (query.operation == OP_READ) ? pos_hit : eq;
	end

	assign link_out = '{lt: lt, data: data_q};
	assign ans_out  = ans_q;

	// element storage, shifted up from the lower neighbor on insert
	always_ff @(posedge clk) begin
		if (query.shift && !lt) begin
			data_q <= prev.lt ? query.value : prev.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ans_q <= '0;
		end else if (hit) begin
			ans_q <= '{hit: 1'b1, data: data_q};
		end else begin
			ans_q <= ans_in;
		end
	end

endmodule

/* rtl/sorted_integer_set.sv */
// ----------------------------------------------------------------------------
// sorted_integer_set
// sequence: an accepted item is searched while answers ripple the full cell
//   chain down to cell zero, then applied into the output register;
//   no new item is taken until the previous one has been applied
// reset: count clears at once, no clearing pass; element cells are not reset
// ----------------------------------------------------------------------------
module sorted_integer_set
	import sis_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic            clk,
	input  logic            arst_n,
	sis_chan_if.sink        req,
	sis_chan_if.source      rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_APPLY
	} state_t;

	state_t        state_q;
	logic [CW-1:0] sweep_q;     // search cycles left
	logic [CW-1:0] count_q;     // elements held
	req_t          item_q;      // item under work
	logic          out_valid_q;
	rsp_t          out_q;

	query_t        query;
	link_t         lk [CAPACITY];
	ans_t          ans [CAPACITY];
	logic          apply_fire;
	logic          not_full;
	logic [CW-1:0] new_count;
	logic [31:0]   count_wide;
	rsp_t          result;

	// new item only when the chain is free
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// result register must be free or draining to finish an item
	assign apply_fire = (state_q == S_APPLY) && (!out_valid_q || rsp.ready);
	assign not_full   = count_q < CW'(CAPACITY);

	// broadcast query; shift only on an insert of a new value with room left
	always_comb begin
		query.operation = item_q.operation;
		query.value     = item_q.value;
		query.position  = item_q.position;
		query.shift     = apply_fire && (item_q.operation == OP_INSERT) &&
		                  !ans[0].hit && not_full;
	end

	// the chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		link_t prev;
		ans_t  upper;
		if (i == 0) begin : g_first
			// below cell zero everything is smaller than the value
			assign prev = '{lt: 1'b1, data: item_q.value};
		end else begin : g_inner
			assign prev = lk[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_below
			assign upper = ans[i+1];
		end
		sis_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.query    (query),
			.count    (count_q),
			.prev     (prev),
			.link_out (lk[i]),
			.ans_in   (upper),
			.ans_out  (ans[i])
		);
	end

	// result of the item, from the settled answer at cell zero
	always_comb begin
		new_count      = count_q;
		result.found   = 1'b0;
		result.element = '0;
		result.status  = ST_OK;
		case (item_q.operation)
			OP_INSERT: begin
				if (ans[0].hit) begin
					result.found = 1'b1;
				end else if (!not_full) begin
					result.status = ST_FULL;
				end else begin
					new_count = count_q + CW'(1);
				end
			end
			OP_LOOKUP: begin
				result.found = ans[0].hit;
			end
			OP_READ: begin
				if (ans[0].hit) begin
					result.element = ans[0].data;
				end else begin
					result.status = ST_RANGE;
				end
			end
			default: begin
				new_count = '0;
			end
		endcase
		count_wide   = 32'(new_count);
		result.count = count_wide[6:0];
	end

	// sequencer: take item, let answers ripple the whole chain, then apply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sweep_q <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_SEARCH;
						sweep_q <= CW'(CAPACITY - 1);
					end
				end
				S_SEARCH: begin
					if (sweep_q == '0) begin
						state_q <= S_APPLY;
					end else begin
						sweep_q <= sweep_q - CW'(1);
					end
				end
				S_APPLY: begin
					if (apply_fire) begin
						state_q <= S_IDLE;
						count_q <= new_count;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_q <= req.data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			out_q <= result;
		end
	end

	// count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count above capacity");

	// count only steps up by one or clears
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == $past(count_q) + CW'(1) || count_q == '0))
		else $error("count jumped");

	// set is frozen while answers ripple
	a_search_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |=> $stable(count_q))
		else $error("count moved during search");

	// a result appears only after the apply step
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_APPLY))
		else $error("result without apply");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_integer_set. A shadow copy of the set
// predicts every response; requests and responses move with random idle
// gaps on both channels, through directed cases, fill-to-full runs,
// duplicate churn and random noise.
// ----------------------------------------------------------------------------
module tb;
	import sis_pkg::*;

	localparam int CAP        = DEF_CAPACITY;
	localparam int ITEM_GOAL  = 1250;
	localparam int CYCLE_CAP  = 1000000;
	localparam int TAIL_WAIT  = CAP + 8;

	// shadow of the set contents plus the queue of responses still owed
	class set_shadow;
		value_t members[$];
		rsp_t   owed_rsp[$];
		int     mismatches;
		int     checked;
		int     full_rejects;
		int     range_reads;
		int     hits;

		function new();
			mismatches   = 0;
			checked      = 0;
			full_rejects = 0;
			range_reads  = 0;
			hits         = 0;
		endfunction

		function int fill_level();
			return members.size();
		endfunction

		function value_t member_at(int idx);
			return members[idx];
		endfunction

		function int outstanding();
			return owed_rsp.size();
		endfunction

		// first index whose member is not below v
		function int first_not_below(value_t v);
			int idx;
			idx = 0;
			while (idx < members.size() && members[idx] < v)
				idx++;
			return idx;
		endfunction

		function rsp_t apply_op(req_t r);
			rsp_t e;
			int   at;
			e         = '0;
			e.status  = ST_OK;
			case (r.operation)
				OP_INSERT: begin
					at = first_not_below(r.value);
					if (at < members.size() && members[at] == r.value) begin
						e.found = 1'b1;
						hits++;
					end else if (members.size() >= CAP) begin
						e.status = ST_FULL;
						full_rejects++;
					end else begin
						members.insert(at, r.value);
					end
				end
				OP_LOOKUP: begin
					at = first_not_below(r.value);
					if (at < members.size() && members[at] == r.value) begin
						e.found = 1'b1;
						hits++;
					end
				end
				OP_READ: begin
					if (int'(r.position) < members.size() && int'(r.position) < CAP) begin
						e.element = members[r.position];
					end else begin
						e.status = ST_RANGE;
						range_reads++;
					end
				end
				default: begin
					members.delete();
				end
			endcase
			e.count = 7'(members.size());
			return e;
		endfunction

		function void note_request(req_t r);
			owed_rsp.push_back(apply_op(r));
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (owed_rsp.size() == 0) begin
				$error("response with nothing outstanding: found=%0b count=%0d element=%0d status=%0d",
					got.found, got.count, got.element, got.status);
				mismatches++;
				return;
			end
			want = owed_rsp.pop_front();
			checked++;
			if (got.found !== want.found) begin
				$error("found: expected %0b, got %0b", want.found, got.found);
				mismatches++;
			end
			if (got.count !== want.count) begin
				$error("count: expected %0d, got %0d", want.count, got.count);
				mismatches++;
			end
			if (got.element !== want.element) begin
				$error("element: expected %0d, got %0d", want.element, got.element);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sis_chan_if #(.T(req_t)) req_if ();
	sis_chan_if #(.T(rsp_t)) rsp_if ();

	sorted_integer_set #(
		.CAPACITY(CAP)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if.sink),
		.rsp   (rsp_if.source)
	);

	set_shadow shadow = new();

	int  sent;
	int  cycles;
	bit  no_idle;
	int  drains;

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// runaway guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------

	// one item: idle for a random gap, then hold valid until accepted;
	// with a zero gap valid simply stays high from the previous item
	task automatic push_request(input req_t item);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= item;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		shadow.note_request(item);
		sent++;
	endtask

	// drop valid and hold off until every owed response has come back
	task automatic drain_responses();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (shadow.outstanding() != 0)
			@(posedge clk);
		drains++;
	endtask

	task automatic push_op(input op_t op, input value_t v, input logic [5:0] pos);
		req_t r;
		r.operation = op;
		r.value     = v;
		r.position  = pos;
		push_request(r);
	endtask

	// value mix: wide random, edges, a tiny pool for duplicates, or a member
	function automatic value_t pick_value(int kind);
		value_t edges[6];
		edges[0] = value_t'(32'h8000_0000);
		edges[1] = value_t'(32'h7fff_ffff);
		edges[2] = '0;
		edges[3] = '1;
		edges[4] = value_t'(32'h8000_0001);
		edges[5] = value_t'(32'h7fff_fffe);
		case (kind)
			1: return edges[$urandom_range(0, 5)];
			2: return value_t'($signed($urandom_range(0, 15)) - 8);
			3: begin
				if (shadow.fill_level() > 0)
					return shadow.member_at($urandom_range(0, shadow.fill_level() - 1));
				return value_t'($urandom);
			end
			default: return value_t'($urandom);
		endcase
	endfunction

	// read index: mostly inside the set, sometimes anywhere in six bits
	function automatic logic [5:0] pick_position();
		if (shadow.fill_level() > 0 && $urandom_range(0, 3) != 0)
			return 6'($urandom_range(0, shadow.fill_level() - 1));
		return 6'($urandom);
	endfunction

	// empty the set, then mostly inserts of wide values until it is full
	// and between 4 and 36 items past that
	task automatic fill_run();
		int n;
		int dice;
		push_op(OP_CLEAR, value_t'($urandom), 6'($urandom));
		n = $urandom_range(4, 36);
		while (shadow.fill_level() < CAP || n > 0) begin
			if (shadow.fill_level() >= CAP)
				n--;
			dice = $urandom_range(0, 99);
			if (dice < 62)
				push_op(OP_INSERT, pick_value(0), 6'($urandom));
			else if (dice < 72)
				push_op(OP_INSERT, pick_value(3), 6'($urandom));
			else if (dice < 88)
				push_op(OP_READ, value_t'($urandom), pick_position());
			else
				push_op(OP_LOOKUP, pick_value($urandom_range(0, 1) ? 3 : 0), 6'($urandom));
		end
	endtask

	// mixed operations on values of the given kind; with the narrow kinds or set members, duplicates are common
	task automatic churn_run(input int value_kind, input int n);
		int dice;
		repeat (n) begin
			dice = $urandom_range(0, 99);
			if (dice < 40)
				push_op(OP_INSERT, pick_value(value_kind), 6'($urandom));
			else if (dice < 68)
				push_op(OP_LOOKUP, pick_value($urandom_range(0, 2) ? value_kind : 3),
					6'($urandom));
			else if (dice < 96)
				push_op(OP_READ, value_t'($urandom), pick_position());
			else
				push_op(OP_CLEAR, value_t'($urandom), 6'($urandom));
		end
	endtask

	// every field fully random
	task automatic noise_run(input int n);
		repeat (n)
			push_op(op_t'($urandom_range(0, 3)), value_t'($urandom), 6'($urandom));
	endtask

	task automatic directed_cases();
		value_t vmin;
		value_t vmax;
		vmin = value_t'(32'h8000_0000);
		vmax = value_t'(32'h7fff_ffff);
		// empty set
		push_op(OP_LOOKUP, '0, '0);
		push_op(OP_READ, '0, '0);
		// edges of the value range, out of order
		push_op(OP_INSERT, '0, '0);
		push_op(OP_INSERT, vmin, '1);
		push_op(OP_INSERT, vmax, '0);
		push_op(OP_INSERT, '1, '1);
		// duplicates leave the set alone
		push_op(OP_INSERT, '0, '0);
		push_op(OP_INSERT, vmax, '0);
		push_op(OP_LOOKUP, vmin, '0);
		push_op(OP_LOOKUP, value_t'(1), '0);
		push_op(OP_LOOKUP, vmax, '1);
		// reads at both ends and past the count
		push_op(OP_READ, vmax, 6'd0);
		push_op(OP_READ, '0, 6'd3);
		push_op(OP_READ, '0, 6'd4);
		push_op(OP_READ, '1, 6'd63);
		push_op(OP_INSERT, value_t'(32'h5555_5555), 6'h15);
		push_op(OP_INSERT, value_t'(32'haaaa_aaaa), 6'h2a);
		push_op(OP_READ, '0, 6'd1);
		push_op(OP_READ, '0, 6'd5);
		// clear and what follows it
		push_op(OP_CLEAR, vmax, '1);
		push_op(OP_LOOKUP, vmax, '0);
		push_op(OP_READ, '0, 6'd0);
		push_op(OP_INSERT, value_t'(5), '0);
		push_op(OP_CLEAR, '0, '0);
	endtask

	initial begin
		int episode;
		int kind;
		arst_n        = 1'b0;
		req_if.valid  = 1'b0;
		req_if.data   = '0;
		sent          = 0;
		cycles        = 0;
		drains        = 0;
		no_idle       = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_cases();
		drain_responses();

		// first episode always fills the set so the full case is reached
		episode = 0;
		while (sent < ITEM_GOAL) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if (episode > 0 && $urandom_range(0, 3) == 0)
				drain_responses();
			kind = (episode == 0) ? 0 : $urandom_range(0, 5);
			case (kind)
				0, 1:    fill_run();
				2:       churn_run(2, $urandom_range(20, 60));
				3:       churn_run(1, $urandom_range(15, 30));
				4:       churn_run($urandom_range(0, 1) ? 0 : 3, $urandom_range(20, 50));
				default: noise_run($urandom_range(10, 30));
			endcase
			episode++;
		end

		drain_responses();
		// anything arriving now is an unexpected extra response
		repeat (TAIL_WAIT) @(posedge clk);

		$display("run: %0d requests, %0d responses checked, %0d pauses to drain",
			sent, shadow.checked, drains);
		$display("run: %0d hits, %0d inserts refused on a full set, %0d reads past the count",
			shadow.hits, shadow.full_rejects, shadow.range_reads);
		if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// response side: random stall per item, ready stays up when the draw is zero
	// ------------------------------------------------------------------
	initial begin
		int stall;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid)
				@(posedge clk);
			shadow.check_response(rsp_if.data);
		end
	end

endmodule

/* sorted_integer_set.f */
rtl/sis_pkg.sv
rtl/sis_chan_if.sv
rtl/sis_cell.sv
rtl/sorted_integer_set.sv
dv/tb.sv
